// File: rtl/pce_pkg.sv
// Package for the programmable CRC engine: widths, codes, reset values, types.
// No dependencies; every other file in rtl/ imports it.

package pce_pkg;

    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 64;
    localparam int HALF_W     = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int BIT_STEPS  = 8;

    typedef logic [CRC_W-1:0]     t_crc;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // CRC mode codes; the unused code behaves as reflected 32-bit
    localparam t_mode MODE_REFL32 = 2'd0;
    localparam t_mode MODE_REFL64 = 2'd1;
    localparam t_mode MODE_FWD32  = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx REG_POLYNOMIAL = 1'b0;
    localparam t_cfg_idx REG_CRC_MODE   = 1'b1;

    localparam t_crc  POLY_RESET = 64'h0000_0000_EDB8_8320;
    localparam t_crc  CRC_INIT   = {CRC_W{1'b1}};
    localparam t_mode MODE_RESET = MODE_REFL32;

    // step unit control, travels from the top level to the datapath
    typedef struct packed {
        t_mode mode;
        t_crc  poly;
    } t_step_ctrl;

endpackage

// File: rtl/pce_in_if.sv
// Byte channel of the CRC engine: valid/ready handshake plus data_byte/last_byte.
// Depends on pce_pkg.

interface pce_in_if import pce_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/pce_out_if.sv
// Result channel of the CRC engine: valid/ready handshake plus crc_value.
// Depends on pce_pkg.

interface pce_out_if import pce_pkg::*; ();
    logic valid;
    logic ready;
    t_crc crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

// File: rtl/pce_byte_step.sv
// Byte update of the CRC register: eight unrolled XOR-shift steps, reflected
// or forward, 32 or 64 bits wide. Purely combinational. Depends on pce_pkg.

module pce_byte_step import pce_pkg::*; (
    input  t_step_ctrl i_ctrl,
    input  t_crc       i_crc,
    input  t_byte      i_data_byte,
    output t_crc       o_crc
);

    t_crc work;
    t_crc poly;

    always_comb begin
        // narrow the register and polynomial for the 32-bit modes
        case (i_ctrl.mode)
            MODE_REFL64: begin
                work = i_crc;
                poly = i_ctrl.poly;
            end
            default: begin
                work = {{(CRC_W-HALF_W){1'b0}}, i_crc[HALF_W-1:0]};
                poly = {{(CRC_W-HALF_W){1'b0}}, i_ctrl.poly[HALF_W-1:0]};
            end
        endcase

        if (i_ctrl.mode == MODE_FWD32) begin
            // forward: byte into bits 31..24, shift left out of bit 31
            work[HALF_W-1 -: BYTE_W] = work[HALF_W-1 -: BYTE_W] ^ i_data_byte;
            for (int k = 0; k < BIT_STEPS; k++) begin
                if (work[HALF_W-1]) begin
                    work = {{(CRC_W-HALF_W){1'b0}}, work[HALF_W-2:0], 1'b0} ^ poly;
                end else begin
                    work = {{(CRC_W-HALF_W){1'b0}}, work[HALF_W-2:0], 1'b0};
                end
            end
        end else begin
            // reflected: byte into the low bits, shift right out of bit 0
            work[BYTE_W-1:0] = work[BYTE_W-1:0] ^ i_data_byte;
            for (int k = 0; k < BIT_STEPS; k++) begin
                if (work[0]) begin
                    work = (work >> 1) ^ poly;
                end else begin
                    work = work >> 1;
                end
            end
        end
        o_crc = work;
    end

endmodule

// File: rtl/programmable_crc_engine_top.sv
// Top level of the programmable CRC engine: configuration registers, input
// register, CRC register and result register. Depends on pce_pkg, pce_in_if,
// pce_out_if and pce_byte_step.
//
//  channel    dir  payload                   role
//  i_byte_ch  in   data_byte[7:0], last_byte  message bytes, one per transfer
//  o_crc_ch   out  crc_value[63:0]            final CRC, one per message
//  i_cfg_*    in   index[0], data[63:0]       polynomial / crc_mode writes
//
// One byte per cycle sustained unless a last byte waits on a stalled result; a last
// byte's result is formed by the eight-step XOR-shift network between the input
// register and the CRC register and is then held in the result register.
// Reset loads the CRC register with all ones, polynomial 0xEDB88320, mode 0.
// A stalled result blocks the input only when the input register holds a
// last byte; other bytes keep flowing into the CRC register.

module programmable_crc_engine_top import pce_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pce_in_if.sink    i_byte_ch,
    pce_out_if.source o_crc_ch
);

    t_crc       r_poly;
    t_mode      r_mode;
    logic       r_in_valid, n_in_valid;
    t_byte      r_in_byte;
    logic       r_in_last;
    t_crc       r_crc, n_crc;
    logic       r_out_valid, n_out_valid;
    t_crc       r_out_crc, n_out_crc;

    logic       advance;
    logic       in_transfer;
    t_crc       step_crc;
    t_step_ctrl step_ctrl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POLYNOMIAL: r_poly <= i_cfg_data;
                REG_CRC_MODE:   r_mode <= i_cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    // the held byte moves on unless it closes a message and the result slot is stuck
    assign advance     = r_in_valid && (!r_in_last || !r_out_valid || o_crc_ch.ready);
    assign i_byte_ch.ready = !r_in_valid || advance;
    assign in_transfer = i_byte_ch.valid && i_byte_ch.ready;

    assign step_ctrl = '{mode: r_mode, poly: r_poly};

    pce_byte_step u_step (
        .i_ctrl      (step_ctrl),
        .i_crc       (r_crc),
        .i_data_byte (r_in_byte),
        .o_crc       (step_crc)
    );

    // next-state logic for the input stage, CRC register and result slot
    always_comb begin
        n_in_valid  = in_transfer ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_crc       = r_crc;
        n_out_valid = r_out_valid && !o_crc_ch.ready;
        n_out_crc   = r_out_crc;
        if (advance) begin
            n_crc = r_in_last ? CRC_INIT : step_crc;
            if (r_in_last) begin
                n_out_valid = 1'b1;
                if (r_mode == MODE_REFL64) begin
                    n_out_crc = ~step_crc;
                end else begin
                    n_out_crc = {{(CRC_W-HALF_W){1'b0}}, ~step_crc[HALF_W-1:0]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_transfer) begin
            r_in_byte <= i_byte_ch.data_byte;
            r_in_last <= i_byte_ch.last_byte;
        end
        r_out_crc <= n_out_crc;
    end

    assign o_crc_ch.valid     = r_out_valid;
    assign o_crc_ch.crc_value = r_out_crc;

endmodule

// File: rtl/pce_checker.sv
// Port-level checks for the programmable CRC engine, bound to the top level.
// Depends on pce_pkg and programmable_crc_engine_top.

module pce_checker import pce_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_crc i_out_crc
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_crc))
        else $error("result changed or vanished while stalled");

    // a result only leaves by a transfer
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_out_valid) |-> $past(i_out_ready))
        else $error("result withdrawn without a transfer");

    // input back-pressure only comes from a stuck result
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while the result slot is free");

    // a fresh result is raised once its last byte's transfer has passed through
    // the input register and into the result register
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result without a preceding last byte");

endmodule

bind programmable_crc_engine_top pce_checker u_pce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte_ch.valid),
    .i_in_ready  (i_byte_ch.ready),
    .i_in_last   (i_byte_ch.last_byte),
    .i_out_valid (o_crc_ch.valid),
    .i_out_ready (o_crc_ch.ready),
    .i_out_crc   (o_crc_ch.crc_value)
);

// File: sim/tb_top.sv
// Testbench for programmable_crc_engine_top: directed and random byte messages
// checked against an in-bench CRC predictor, with configuration changes between
// and inside messages. Depends on pce_pkg, pce_in_if, pce_out_if and the RTL.

module tb_top;
    import pce_pkg::*;

    localparam t_mode MODE_UNUSED   = 2'd3;
    localparam t_crc  LOW32         = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
    localparam t_crc  POLY_CRC64_XZ = 64'hC96C_5795_D787_0F42;
    localparam t_crc  POLY_CRC32_FWD = 64'h0000_0000_04C1_1DB7;
    localparam int    RANDOM_BYTES  = 2000;
    localparam int    SETTLE_CYCLES = 6;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    STALL_LIMIT   = 4000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pce_in_if  byte_ch ();
    pce_out_if crc_ch ();

    programmable_crc_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte_ch   (byte_ch),
        .o_crc_ch    (crc_ch)
    );

    // predictor state: running CRC and its own copy of the configuration
    t_crc  crc_acc;
    t_crc  poly_cfg;
    t_mode mode_cfg;
    t_crc  crc_expected[$];

    int   mismatches;
    int   bytes_sent;
    int   idle_cycles;
    bit   gaps_on;
    bit   stalls_on;
    bit   hold_req;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // one byte through the CRC shift network under the given mode
    function automatic t_crc crc_next_byte(t_crc acc, t_crc poly, t_mode mode, t_byte b);
        t_crc r;
        t_crc p32;
        p32 = poly & LOW32;
        case (mode)
            MODE_REFL64: begin
                r = acc ^ t_crc'(b);
                for (int k = 0; k < BIT_STEPS; k++)
                    r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
            end
            MODE_FWD32: begin
                r = (acc ^ (t_crc'(b) << (HALF_W - BYTE_W))) & LOW32;
                for (int k = 0; k < BIT_STEPS; k++)
                    r = r[HALF_W-1] ? (((r << 1) ^ p32) & LOW32) : ((r << 1) & LOW32);
            end
            default: begin
                // reflected 32-bit, also taken by the unused mode code
                r = (acc & LOW32) ^ t_crc'(b);
                for (int k = 0; k < BIT_STEPS; k++)
                    r = r[0] ? ((r >> 1) ^ p32) : (r >> 1);
                r = r & LOW32;
            end
        endcase
        return r;
    endfunction

    // fold an accepted byte into the predictor; a last byte yields a result
    function automatic void absorb_byte(t_byte b, logic is_last);
        t_crc crc_out;
        crc_acc = crc_next_byte(crc_acc, poly_cfg, mode_cfg, b);
        if (is_last) begin
            crc_out = (crc_acc ^ CRC_INIT) &
                      ((mode_cfg == MODE_REFL64) ? CRC_INIT : LOW32);
            crc_expected = {crc_expected, crc_out};
            crc_acc = CRC_INIT;
        end
    endfunction

    // offer one byte, with an optional random gap first; returns at the
    // rising edge of the transfer
    task automatic send_byte(input t_byte b, input logic is_last);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        absorb_byte(b, is_last);
        bytes_sent++;
    endtask

    // stop offering, then wait for every pending CRC and for the pipeline
    // to settle so that configuration may change
    task automatic wait_drained();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (crc_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write; only called with the block drained
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_POLYNOMIAL)
            poly_cfg = value;
        else
            mode_cfg = value[MODE_W-1:0];
    endtask

    task automatic write_mode(input t_mode mode);
        // upper data bits carry noise the block must ignore
        write_reg(REG_CRC_MODE, {$urandom, $urandom_range(0, 1) ? $urandom : 32'd0}
                                & ~64'(3) | 64'(mode));
    endtask

    function automatic t_crc pick_poly();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CRC_INIT;
            2:       return POLY_RESET;
            3:       return POLY_CRC64_XZ;
            4:       return POLY_CRC32_FWD;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result checker: oldest expectation against each transfer
    always @(posedge i_clk) begin
        if (i_rst_n && crc_ch.valid && crc_ch.ready) begin
            if (crc_expected.size() == 0) begin
                $display("%0t: unexpected crc_value %h", $time, crc_ch.crc_value);
                mismatches++;
            end else begin
                if (crc_ch.crc_value !== crc_expected[0]) begin
                    $display("%0t: crc_value expected %h actual %h",
                             $time, crc_expected[0], crc_ch.crc_value);
                    mismatches++;
                end
                void'(crc_expected.pop_front());
            end
        end
    end

    // receiver: random stall bursts, plus one long hold when requested
    initial begin
        int stall_left;
        stall_left   = 0;
        crc_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                crc_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                crc_ch.ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                stall_left   = $urandom_range(0, 3);
                crc_ch.ready <= 1'b0;
            end else begin
                crc_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (crc_ch.valid && crc_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // default configuration: check value message, single-byte extremes
    task automatic test_reset_defaults();
        t_byte msg[9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        foreach (msg[i])
            send_byte(msg[i], i == 8);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // every mode code, including the unused one, and polynomial extremes
    task automatic test_modes();
        t_mode modes[4] = '{MODE_REFL64, MODE_FWD32, MODE_UNUSED, MODE_REFL32};
        foreach (modes[i]) begin
            write_mode(modes[i]);
            if (modes[i] == MODE_REFL64)
                write_reg(REG_POLYNOMIAL, POLY_CRC64_XZ);
            else if (modes[i] == MODE_FWD32)
                write_reg(REG_POLYNOMIAL, POLY_CRC32_FWD);
            else
                write_reg(REG_POLYNOMIAL, POLY_RESET);
            send_byte(8'h00, 1'b0);
            send_byte(8'hFF, 1'b1);
            wait_drained();
        end
        write_reg(REG_POLYNOMIAL, '0);
        write_mode(MODE_REFL64);
        send_byte(8'hA5, 1'b1);
        wait_drained();
        write_reg(REG_POLYNOMIAL, CRC_INIT);
        write_mode(MODE_FWD32);
        send_byte(8'h5A, 1'b1);
        wait_drained();
    endtask

    // mode and polynomial changes with a message half done
    task automatic test_mid_message();
        send_byte(8'h12, 1'b0);
        wait_drained();
        write_mode(MODE_REFL64);
        send_byte(8'h34, 1'b0);
        wait_drained();
        write_reg(REG_POLYNOMIAL, {$urandom, $urandom});
        send_byte(8'h56, 1'b0);
        wait_drained();
        write_mode(MODE_REFL32);
        send_byte(8'h78, 1'b1);
        wait_drained();
    endtask

    // long receiver hold while short messages keep coming
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (30) send_byte(t_byte'($urandom), $urandom_range(0, 2) != 0);
        send_byte(t_byte'($urandom), 1'b1);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // random messages with random configuration; quiet handshakes at the end
    task automatic test_random_messages();
        int len;
        int mid_at;
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            if (bytes_sent - start_count > (RANDOM_BYTES * 4) / 5) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
                if ($urandom_range(0, 1)) write_reg(REG_POLYNOMIAL, pick_poly());
                write_mode(t_mode'($urandom_range(0, 3)));
            end
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48)
                                                 : $urandom_range(1, 8);
            mid_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : 0;
            for (int i = 1; i <= len; i++) begin
                if (i == mid_at && i > 1) begin
                    wait_drained();
                    if ($urandom_range(0, 1))
                        write_reg(REG_POLYNOMIAL, pick_poly());
                    else
                        write_mode(t_mode'($urandom_range(0, 3)));
                end
                send_byte(t_byte'($urandom), i == len);
            end
        end
        wait_drained();
    endtask

    // stimulus sequence
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = REG_POLYNOMIAL;
        i_cfg_data        = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        crc_acc           = CRC_INIT;
        poly_cfg          = POLY_RESET;
        mode_cfg          = MODE_RESET;
        mismatches        = 0;
        bytes_sent        = 0;
        idle_cycles       = 0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        hold_req          = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_modes();
        test_mid_message();
        test_backpressure();
        test_random_messages();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && crc_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
